// File: rtl/setf_pkg.sv
// Shared types, codes and constants for the scalar element to float32 converter.
// No dependencies.
package setf_pkg;
    localparam logic [3:0] ET_INT8   = 4'd0;
    localparam logic [3:0] ET_UINT8  = 4'd1;
    localparam logic [3:0] ET_INT16  = 4'd2;
    localparam logic [3:0] ET_UINT16 = 4'd3;
    localparam logic [3:0] ET_INT32  = 4'd4;
    localparam logic [3:0] ET_UINT32 = 4'd5;
    localparam logic [3:0] ET_INT64  = 4'd6;
    localparam logic [3:0] ET_UINT64 = 4'd7;
    localparam logic [3:0] ET_FLOAT  = 4'd8;
    localparam logic [3:0] ET_DOUBLE = 4'd9;
    localparam logic [3:0] ET_RESET  = ET_UINT8;

    localparam logic [1:0] REG_ELEMENT_TYPE = 2'd0;
    localparam logic [1:0] REG_BYTE_ORDER   = 2'd1;

    localparam logic [1:0] K_ZERO = 2'd0;
    localparam logic [1:0] K_DIRECT = 2'd1;
    localparam logic [1:0] K_ROUND = 2'd2;

    // Word handed from the front end to the normalizer.
    typedef struct packed {
        logic        sign;
        logic [1:0]  kind;
        logic [31:0] direct;
        logic [63:0] sig;
        logic signed [12:0] e2;
    } prep_t;

    // Word handed from the normalizer to the rounder.
    typedef struct packed {
        logic        sign;
        logic [1:0]  kind;
        logic [31:0] direct;
        logic [63:0] norm;
        logic signed [12:0] q;
    } norm_t;
endpackage

// File: rtl/setf_front.sv
// Stage 1: byte assembly, sign handling and double field split.
// Depends on setf_pkg.
module setf_front
    import setf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] raw_bytes,
    input  logic [3:0]  element_type,
    input  logic        byte_order,
    output logic        out_valid,
    output prep_t       out_word
);
    logic        valid_reg;
    prep_t       word_reg;
    prep_t       word_next;
    logic [63:0] word;
    logic [63:0] mag;
    logic [3:0]  nbytes;
    logic        neg;

    always_comb
    begin
        case (element_type)
            ET_INT8, ET_UINT8:   nbytes = 4'd1;
            ET_INT16, ET_UINT16: nbytes = 4'd2;
            ET_INT32, ET_UINT32, ET_FLOAT: nbytes = 4'd4;
            default: nbytes = 4'd8;
        endcase
        word = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (k < int'(nbytes))
            begin
                if (byte_order)
                    word[8*(int'(nbytes)-1-k) +: 8] = raw_bytes[8*k +: 8];
                else
                    word[8*k +: 8] = raw_bytes[8*k +: 8];
            end
        end
        neg = 1'b0;
        case (element_type)
            ET_INT8:  neg = word[7];
            ET_INT16: neg = word[15];
            ET_INT32: neg = word[31];
            ET_INT64: neg = word[63];
            default:  neg = 1'b0;
        endcase
        mag = '0;
        case (nbytes)
            4'd1: mag[7:0]  = neg ? 8'(-word[7:0]) : word[7:0];
            4'd2: mag[15:0] = neg ? 16'(-word[15:0]) : word[15:0];
            4'd4: mag[31:0] = neg ? 32'(-word[31:0]) : word[31:0];
            default: mag = neg ? 64'(-word) : word;
        endcase
        word_next.sign   = neg;
        word_next.kind   = K_ROUND;
        word_next.direct = '0;
        word_next.sig    = mag;
        word_next.e2     = '0;
        if (element_type > ET_DOUBLE)
        begin
            word_next.sign = 1'b0;
            word_next.kind = K_ZERO;
        end
        else if (element_type == ET_FLOAT)
        begin
            word_next.sign   = 1'b0;
            word_next.kind   = K_DIRECT;
            word_next.direct = word[31:0];
        end
        else if (element_type == ET_DOUBLE)
        begin
            word_next.sign = word[63];
            if (word[62:52] == 11'h7FF)
            begin
                word_next.kind = K_DIRECT;
                if (word[51:0] == '0)
                    word_next.direct = {word[63], 31'h7F800000};
                else
                    word_next.direct = {word[63], 8'hFF, 1'b1, word[50:29]};
            end
            else if (word[62:52] == '0)
            begin
                word_next.sig = {12'd0, word[51:0]};
                word_next.e2  = -13'sd1074;
            end
            else
            begin
                word_next.sig = {11'd0, 1'b1, word[51:0]};
                word_next.e2  = $signed({2'b00, word[62:52]}) - 13'sd1075;
            end
        end
        if (word_next.kind == K_ROUND && word_next.sig == '0)
            word_next.kind = K_ZERO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
endmodule

// File: rtl/setf_norm.sv
// Stage 2: leading-one detection and left normalization of the significand.
// Depends on setf_pkg.
module setf_norm
    import setf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  prep_t in_word,
    output logic  out_valid,
    output norm_t out_word
);
    logic  valid_reg;
    norm_t word_reg;
    norm_t word_next;
    logic [5:0] lz;

    always_comb
    begin
        lz = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (in_word.sig[i])
                lz = 6'(63 - i);
        end
        word_next.sign   = in_word.sign;
        word_next.kind   = in_word.kind;
        word_next.direct = in_word.direct;
        word_next.norm   = in_word.sig << lz;
        word_next.q      = in_word.e2 + 13'sd63 - $signed({7'd0, lz});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
endmodule

// File: rtl/setf_round.sv
// Stage 3: denormal shift, round to nearest even and float32 packing.
// Depends on setf_pkg.
module setf_round
    import setf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  norm_t       in_word,
    output logic        out_valid,
    output logic [31:0] out_bits
);
    logic        valid_reg;
    logic [31:0] bits_reg;
    logic [31:0] bits_next;
    logic signed [12:0] dsh;
    logic [6:0]  sh;
    logic [63:0] shifted;
    logic        sticky;
    logic [24:0] kept;
    logic        rbit;
    logic        rest;
    logic signed [12:0] biased;

    always_comb
    begin
        // Value is norm * 2^(q-63) with leading one at bit 63; q is the exponent.
        dsh = -13'sd126 - in_word.q;
        if (dsh <= 0)
            sh = '0;
        else if (dsh > 13'sd64)
            sh = 7'd64;
        else
            sh = dsh[6:0];
        shifted = (sh >= 7'd64) ? 64'd0 : (in_word.norm >> sh);
        sticky = 1'b0;
        for (int i = 0; i < 64; i++)
        begin
            if (i < int'(sh) && in_word.norm[i])
                sticky = 1'b1;
        end
        rbit = shifted[39];
        rest = (shifted[38:0] != '0) || sticky;
        kept = {1'b0, shifted[63:40]};
        if (rbit && (rest || kept[0]))
            kept = kept + 25'd1;
        biased = (dsh > 0) ? 13'sd1 : in_word.q + 13'sd127;
        if (kept[24])
        begin
            kept = kept >> 1;
            biased = biased + 13'sd1;
        end
        if (dsh > 0 && !kept[23])
            biased = '0;
        case (in_word.kind)
            K_ZERO:   bits_next = {in_word.sign, 31'd0};
            K_DIRECT: bits_next = in_word.direct;
            default:
            begin
                if (biased >= 13'sd255)
                    bits_next = {in_word.sign, 31'h7F800000};
                else
                    bits_next = {in_word.sign, biased[7:0], kept[22:0]};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end

    assign out_valid = valid_reg;
    assign out_bits  = bits_reg;
endmodule

// File: rtl/scalar_element_to_float32.sv
// Top level of the scalar element to float32 converter: APB registers and pipeline.
// Depends on setf_pkg, setf_front, setf_norm and setf_round.
//
// Converts one element per clock: busy is always low, so a start is taken in
// every cycle, and its float32 word appears on float_bits with done high for
// one cycle only, after the three pipeline stages (assembly, normalization,
// rounding). The receiver cannot stall.
module scalar_element_to_float32
    import setf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] raw_bytes,
    output logic        done,
    output logic [31:0] float_bits,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [3:0] element_type_reg;
    logic       byte_order_reg;
    logic       v1;
    logic       v2;
    prep_t      w1;
    norm_t      w2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_type_reg <= ET_RESET;
            byte_order_reg   <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_BYTE_ORDER[0])
                byte_order_reg <= pwdata[0];
            else
                element_type_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ELEMENT_TYPE[0]: prdata = {28'd0, element_type_reg};
            default:             prdata = {31'd0, byte_order_reg};
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    setf_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .raw_bytes(raw_bytes),
        .element_type(element_type_reg), .byte_order(byte_order_reg),
        .out_valid(v1), .out_word(w1)
    );

    setf_norm u_norm (
        .clk(clk), .rst_n(rst_n), .in_valid(v1), .in_word(w1),
        .out_valid(v2), .out_word(w2)
    );

    setf_round u_round (
        .clk(clk), .rst_n(rst_n), .in_valid(v2), .in_word(w2),
        .out_valid(done), .out_bits(float_bits)
    );
endmodule
